// File: rtl/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg: shared types and constants of the servo recipe sequencer.
// Holds the item kinds, recipe opcodes, user actions and status codes.
// ----------------------------------------------------------------------------
package srs_pkg;

  typedef enum logic [1:0] {
    ITEM_TICK = 2'd0,
    ITEM_LOAD = 2'd1,
    ITEM_USER = 2'd2
  } item_op_t;

  typedef enum logic [2:0] {
    ROP_END     = 3'd0,
    ROP_MOVE    = 3'd1,
    ROP_WAIT    = 3'd2,
    ROP_SKIP    = 3'd3,
    ROP_LOOP    = 3'd4,
    ROP_ENDLOOP = 3'd5,
    ROP_NONE    = 3'd6,
    ROP_BREAK   = 3'd7
  } recipe_op_t;

  typedef enum logic [2:0] {
    USR_CONTINUE = 3'd0,
    USR_PAUSE    = 3'd1,
    USR_LEFT     = 3'd2,
    USR_RIGHT    = 3'd3,
    USR_NOP      = 3'd4,
    USR_RESTART  = 3'd5
  } user_act_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_PAUSE = 2'd1,
    ST_ERROR = 2'd2
  } run_status_t;

  localparam logic [4:0] MOVE_PARAM_MAX = 5'd6;
  localparam logic [7:0] NUDGE_STEP     = 8'd4;
  localparam logic [7:0] PULSE_MAX      = 8'd255;
  localparam logic [7:0] NUDGE_TOP      = 8'd251;

  typedef struct packed {
    logic [7:0]  pulse;
    run_status_t status;
    logic        manual;
    logic [4:0]  loop_remaining;
    logic        loop_active;
    logic [5:0]  wait_remaining;
    logic        waiting;
  } srs_ctrl_t;

endpackage

// File: rtl/srs_step.sv
// ----------------------------------------------------------------------------
// srs_step: next-state logic for one item
// Runs one recipe word on an unpaused tick or applies one user command.
// ----------------------------------------------------------------------------
module srs_step #(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  srs_pkg::item_op_t  item_op,
  input  logic [2:0]         user_action,
  input  logic [7:0]         word,
  input  srs_pkg::srs_ctrl_t ctrl,
  input  logic [IDX_W-1:0]   step_idx,
  input  logic [IDX_W-1:0]   loop_ret,
  output srs_pkg::srs_ctrl_t ctrl_nxt,
  output logic [IDX_W-1:0]   step_nxt,
  output logic [IDX_W-1:0]   loop_ret_nxt
);

  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] i);
    logic [IDX_W:0] t;
    t = {1'b0, i} + (IDX_W+1)'(1);
    if (t == (IDX_W+1)'(DEPTH)) begin
      return '0;
    end
    return t[IDX_W-1:0];
  endfunction

  srs_pkg::recipe_op_t rop;
  logic [4:0]          param;

  assign rop   = srs_pkg::recipe_op_t'(word[7:5]);
  assign param = word[4:0];

  always_comb begin
    srs_pkg::srs_ctrl_t c;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   ret;
    c   = ctrl;
    idx = step_idx;
    ret = loop_ret;
    case (item_op)
      srs_pkg::ITEM_TICK: begin
        if (ctrl.status != srs_pkg::ST_PAUSE) begin
          case (rop)
            srs_pkg::ROP_END: begin
              c.pulse = '0;
            end
            srs_pkg::ROP_MOVE: begin
              if (param <= srs_pkg::MOVE_PARAM_MAX) begin
                c.pulse = {1'b0, param, 2'b00};
              end else begin
                c.status = srs_pkg::ST_ERROR;
              end
            end
            srs_pkg::ROP_WAIT: begin
              if (param != '0) begin
                if (!c.waiting) begin
                  c.wait_remaining = {1'b0, param};
                  c.waiting        = 1'b1;
                end else begin
                  c.wait_remaining = c.wait_remaining - 6'd1;
                  if (c.wait_remaining == '0) begin
                    c.waiting = 1'b0;
                  end
                end
              end else begin
                c.status = srs_pkg::ST_ERROR;
              end
            end
            srs_pkg::ROP_SKIP: begin
              idx = inc_idx(idx);
            end
            srs_pkg::ROP_LOOP: begin
              if (!c.loop_active) begin
                c.loop_remaining = param;
                ret              = idx;
                c.loop_active    = 1'b1;
              end
            end
            srs_pkg::ROP_ENDLOOP: begin
              if (c.loop_active) begin
                if (c.loop_remaining != '0) begin
                  c.loop_remaining = c.loop_remaining - 5'd1;
                  idx              = ret;
                end else begin
                  c.loop_active = 1'b0;
                end
              end
            end
            srs_pkg::ROP_BREAK: begin
              c.loop_remaining = '0;
            end
            default: begin
            end
          endcase
          if (rop != srs_pkg::ROP_END && !c.waiting) begin
            idx = inc_idx(idx);
          end
        end
      end
      srs_pkg::ITEM_USER: begin
        case (srs_pkg::user_act_t'(user_action))
          srs_pkg::USR_CONTINUE: begin
            c.manual = 1'b0;
            c.status = srs_pkg::ST_RUN;
          end
          srs_pkg::USR_PAUSE: begin
            c.manual = 1'b1;
            c.status = srs_pkg::ST_PAUSE;
          end
          srs_pkg::USR_LEFT: begin
            if (c.manual) begin
              c.pulse = (c.pulse >= srs_pkg::NUDGE_STEP) ?
                        c.pulse - srs_pkg::NUDGE_STEP : '0;
            end
          end
          srs_pkg::USR_RIGHT: begin
            if (c.manual) begin
              c.pulse = (c.pulse <= srs_pkg::NUDGE_TOP) ?
                        c.pulse + srs_pkg::NUDGE_STEP : srs_pkg::PULSE_MAX;
            end
          end
          srs_pkg::USR_RESTART: begin
            c.manual         = 1'b0;
            c.status         = srs_pkg::ST_RUN;
            c.waiting        = 1'b0;
            c.wait_remaining = '0;
            c.loop_active    = 1'b0;
            c.loop_remaining = '0;
            idx              = '0;
            ret              = '0;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    ctrl_nxt     = c;
    step_nxt     = idx;
    loop_ret_nxt = ret;
  end

endmodule

// File: rtl/servo_recipe_sequencer.sv
// ----------------------------------------------------------------------------
// servo_recipe_sequencer: one servo channel driven by a stored recipe
// Each item passes through the input register and then the result register.
// Throughput is one item per cycle; the input stalls only while the result
// register is full and the output is stalled.
// Synchronous active-low reset clears all control state; the recipe store
// is not cleared and holds nothing defined until written.
// ----------------------------------------------------------------------------
module servo_recipe_sequencer #(
  parameter int RECIPE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [4:0] in_load_index,
  input  logic [7:0] in_recipe_word,
  input  logic [2:0] in_user_action,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_pulse_width,
  output logic [1:0] out_run_status,
  output logic [4:0] out_program_index
);

  localparam int IW = $clog2(RECIPE_DEPTH);

  logic       in_valid_r;
  logic [1:0] in_opcode_r;
  logic [4:0] in_load_index_r;
  logic [7:0] in_recipe_word_r;
  logic [2:0] in_user_action_r;

  logic       out_valid_r;
  logic [7:0] out_pulse_width_r;
  logic [1:0] out_run_status_r;
  logic [4:0] out_program_index_r;

  srs_pkg::srs_ctrl_t ctrl_r, ctrl_nxt;
  logic [IW-1:0]      step_idx_r, step_nxt;
  logic [IW-1:0]      loop_ret_r, loop_ret_nxt;

  logic [7:0]    recipe_mem [RECIPE_DEPTH];
  logic [7:0]    rd_data_r;
  logic          byp_r;
  logic [7:0]    byp_data_r;
  logic [7:0]    word;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_pos;
  logic          mem_we;
  logic          advance;
  logic [8:0]    idx_ext;

  assign advance  = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;

  always_comb begin
    logic [8:0] p;
    p = {4'b0, in_load_index_r};
    for (int k = 0; k < 4; k++) begin
      if (p >= 9'(RECIPE_DEPTH)) begin
        p = p - 9'(RECIPE_DEPTH);
      end
    end
    wr_pos = p[IW-1:0];
  end

  assign mem_we  = advance && (srs_pkg::item_op_t'(in_opcode_r) == srs_pkg::ITEM_LOAD);
  assign rd_addr = advance ? step_nxt : step_idx_r;
  assign word    = byp_r ? byp_data_r : rd_data_r;
  assign idx_ext = 9'(step_nxt);

  srs_step #(
    .DEPTH (RECIPE_DEPTH),
    .IDX_W (IW)
  ) u_step (
    .item_op      (srs_pkg::item_op_t'(in_opcode_r)),
    .user_action  (in_user_action_r),
    .word         (word),
    .ctrl         (ctrl_r),
    .step_idx     (step_idx_r),
    .loop_ret     (loop_ret_r),
    .ctrl_nxt     (ctrl_nxt),
    .step_nxt     (step_nxt),
    .loop_ret_nxt (loop_ret_nxt)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      recipe_mem[wr_pos] <= in_recipe_word_r;
    end
    rd_data_r  <= recipe_mem[rd_addr];
    byp_r      <= mem_we && (wr_pos == rd_addr);
    byp_data_r <= in_recipe_word_r;
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_opcode_r      <= in_opcode;
      in_load_index_r  <= in_load_index;
      in_recipe_word_r <= in_recipe_word;
      in_user_action_r <= in_user_action;
    end
    if (advance) begin
      out_pulse_width_r   <= ctrl_nxt.pulse;
      out_run_status_r    <= ctrl_nxt.status;
      out_program_index_r <= idx_ext[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ctrl_r      <= '0;
      step_idx_r  <= '0;
      loop_ret_r  <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        ctrl_r      <= ctrl_nxt;
        step_idx_r  <= step_nxt;
        loop_ret_r  <= loop_ret_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pulse_width   = out_pulse_width_r;
  assign out_run_status    = out_run_status_r;
  assign out_program_index = out_program_index_r;

endmodule

// File: rtl/srs_checker.sv
// ----------------------------------------------------------------------------
// srs_checker: port-level checks for the servo recipe sequencer
// Watches the handshakes and result codes and is bound to the top level.
// ----------------------------------------------------------------------------
module srs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_pulse_width,
  input logic [1:0] out_run_status,
  input logic [4:0] out_program_index
);

  // The input only waits while a result is held back by the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_run_status <= srs_pkg::ST_ERROR))
    else $error("undefined run status");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_pulse_width) &&
      $stable(out_run_status) && $stable(out_program_index)))
    else $error("stalled result item changed");

endmodule

bind servo_recipe_sequencer srs_checker u_srs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_pulse_width   (out_pulse_width),
  .out_run_status    (out_run_status),
  .out_program_index (out_program_index)
);

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the servo recipe sequencer
// Sends recipe loads, timer ticks and user commands, predicts every result
// item with a behavioral copy of the sequencer and checks the results in
// order, with random idling on both channels and one long back-pressure phase.
// ----------------------------------------------------------------------------
module tb_top;
  import srs_pkg::*;

  localparam logic [1:0] ITEM_SPARE   = 2'd3;
  localparam logic [2:0] USR_SPARE_LO = 3'd6;
  localparam logic [2:0] USR_SPARE_HI = 3'd7;
  localparam int ITEM_TARGET = 950;
  localparam int HOLD_AT     = 250;
  localparam int HOLD_CYCLES = 90;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [7:0]  pulse;
    run_status_t status;
    logic [4:0]  index;
  } servo_view_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  idx;
    logic [7:0]  word;
    logic [2:0]  act;
    logic        drain;
    logic [3:0]  gap;
    servo_view_t res;
  } servo_item_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_opcode = '0;
  logic [4:0] in_load_index = '0;
  logic [7:0] in_recipe_word = '0;
  logic [2:0] in_user_action = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_pulse_width;
  logic [1:0] out_run_status;
  logic [4:0] out_program_index;

  logic [7:0]  mdl_store [32];
  bit          mdl_written [32];
  logic [4:0]  mdl_index = '0;
  logic [7:0]  mdl_pulse = '0;
  run_status_t mdl_status = ST_RUN;
  bit          mdl_manual;
  logic [4:0]  mdl_loop_cnt = '0;
  bit          mdl_loop_on;
  logic [4:0]  mdl_loop_ret = '0;
  logic [5:0]  mdl_wait_cnt = '0;
  bit          mdl_waiting;

  servo_item_t pending_items[$];
  servo_view_t expected_views[$];
  servo_item_t in_flight;
  servo_view_t want;
  int          n_items;
  int          n_live;
  int          n_taken;
  int          n_seen;
  int          n_bad;
  int          send_gap;
  int          rx_wait;
  bit          hold_done;
  int          quiet_cycles;

  servo_recipe_sequencer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_load_index    (in_load_index),
    .in_recipe_word   (in_recipe_word),
    .in_user_action   (in_user_action),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pulse_width  (out_pulse_width),
    .out_run_status   (out_run_status),
    .out_program_index(out_program_index)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic servo_view_t step_servo(input logic [1:0] op, input logic [4:0] idx,
                                             input logic [7:0] word, input logic [2:0] act);
    recipe_op_t rop;
    logic [4:0] prm;
    rop = recipe_op_t'(mdl_store[mdl_index][7:5]);
    prm = mdl_store[mdl_index][4:0];
    case (op)
      ITEM_TICK: begin
        if (mdl_status != ST_PAUSE) begin
          case (rop)
            ROP_END: mdl_pulse = 8'd0;
            ROP_MOVE: begin
              if (prm <= MOVE_PARAM_MAX) mdl_pulse = {1'b0, prm, 2'b00};
              else mdl_status = ST_ERROR;
            end
            ROP_WAIT: begin
              if (prm == 5'd0) begin
                mdl_status = ST_ERROR;
              end else if (!mdl_waiting) begin
                mdl_wait_cnt = {1'b0, prm};
                mdl_waiting = 1'b1;
              end else begin
                mdl_wait_cnt = mdl_wait_cnt - 6'd1;
                if (mdl_wait_cnt == 6'd0) mdl_waiting = 1'b0;
              end
            end
            ROP_SKIP: mdl_index = mdl_index + 5'd1;
            ROP_LOOP: begin
              if (!mdl_loop_on) begin
                mdl_loop_cnt = prm;
                mdl_loop_ret = mdl_index;
                mdl_loop_on = 1'b1;
              end
            end
            ROP_ENDLOOP: begin
              if (mdl_loop_on) begin
                if (mdl_loop_cnt != 5'd0) begin
                  mdl_loop_cnt = mdl_loop_cnt - 5'd1;
                  mdl_index = mdl_loop_ret;
                end else begin
                  mdl_loop_on = 1'b0;
                end
              end
            end
            ROP_BREAK: mdl_loop_cnt = 5'd0;
            default: ;
          endcase
          if (rop != ROP_END && !mdl_waiting) mdl_index = mdl_index + 5'd1;
        end
      end
      ITEM_LOAD: begin
        mdl_store[idx] = word;
        mdl_written[idx] = 1'b1;
      end
      ITEM_USER: begin
        case (act)
          USR_CONTINUE: begin
            mdl_manual = 1'b0;
            mdl_status = ST_RUN;
          end
          USR_PAUSE: begin
            mdl_manual = 1'b1;
            mdl_status = ST_PAUSE;
          end
          USR_LEFT: begin
            if (mdl_manual) mdl_pulse = (mdl_pulse >= NUDGE_STEP) ? mdl_pulse - NUDGE_STEP : 8'd0;
          end
          USR_RIGHT: begin
            if (mdl_manual) mdl_pulse = (mdl_pulse <= NUDGE_TOP) ? mdl_pulse + NUDGE_STEP : PULSE_MAX;
          end
          USR_RESTART: begin
            mdl_manual = 1'b0;
            mdl_index = 5'd0;
            mdl_status = ST_RUN;
            mdl_waiting = 1'b0;
            mdl_wait_cnt = 6'd0;
            mdl_loop_on = 1'b0;
            mdl_loop_cnt = 5'd0;
            mdl_loop_ret = 5'd0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return '{mdl_pulse, mdl_status, mdl_index};
  endfunction

  function automatic int draw_idle(input int phase);
    case ((phase / 40) % 3)
      0: return 0;
      1: return $urandom_range(0, 3);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic [7:0] rand_word();
    recipe_op_t rop;
    logic [4:0] prm;
    rop = recipe_op_t'($urandom_range(0, 7));
    if (rop == ROP_END && $urandom_range(0, 3) != 0) rop = ROP_MOVE;
    prm = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 6));
    return {rop, prm};
  endfunction

  task automatic push_item(input logic [1:0] op, input logic [4:0] idx,
                           input logic [7:0] word, input logic [2:0] act);
    servo_item_t it;
    it.op = op;
    it.idx = idx;
    it.word = word;
    it.act = act;
    it.drain = (n_items == 400 || n_items == 760);
    it.gap = 4'(draw_idle(n_items));
    it.res = step_servo(op, idx, word, act);
    pending_items.push_back(it);
    n_items++;
    if (op == ITEM_TICK || op == ITEM_LOAD ||
        (op == ITEM_USER && act <= USR_RESTART && act != USR_NOP)) n_live++;
  endtask

  task automatic send_load(input logic [4:0] idx, input logic [7:0] word);
    push_item(ITEM_LOAD, idx, word, 3'($urandom));
  endtask

  task automatic send_user(input logic [2:0] act);
    push_item(ITEM_USER, 5'($urandom), 8'($urandom), act);
  endtask

  // A running tick must never read a recipe word that was never loaded.
  task automatic send_tick();
    if (mdl_status != ST_PAUSE && !mdl_written[mdl_index]) send_load(mdl_index, rand_word());
    push_item(ITEM_TICK, 5'($urandom), 8'($urandom), 3'($urandom));
  endtask

  initial begin
    int         len;
    logic [1:0] op;
    send_user(USR_RIGHT);
    send_load(5'd0, {ROP_MOVE, 5'd6});
    send_load(5'd1, {ROP_MOVE, 5'd7});
    send_load(5'd2, {ROP_WAIT, 5'd0});
    send_load(5'd3, {ROP_WAIT, 5'd1});
    send_load(5'd4, {ROP_SKIP, 5'd0});
    send_load(5'd6, {ROP_LOOP, 5'd0});
    send_load(5'd7, {ROP_LOOP, 5'd3});
    send_load(5'd8, {ROP_ENDLOOP, 5'd0});
    send_load(5'd9, {ROP_ENDLOOP, 5'd0});
    send_load(5'd10, {ROP_NONE, 5'd31});
    send_load(5'd11, {ROP_BREAK, 5'd31});
    send_load(5'd12, {ROP_END, 5'd0});
    repeat (13) send_tick();
    send_user(USR_CONTINUE);
    send_user(USR_PAUSE);
    send_tick();
    send_user(USR_RIGHT);
    send_user(USR_LEFT);
    send_user(USR_LEFT);
    send_user(USR_CONTINUE);
    send_user(USR_NOP);
    send_user(USR_SPARE_LO);
    send_user(USR_SPARE_HI);
    push_item(ITEM_SPARE, 5'd31, 8'hFF, 3'd7);
    send_user(USR_RESTART);

    while (n_live < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          send_user(USR_RESTART);
          len = $urandom_range(3, 32);
          for (int i = 0; i < len; i++) send_load(5'(i), rand_word());
          repeat ($urandom_range(10, 40)) send_tick();
        end
        2: begin
          send_user(USR_PAUSE);
          repeat ($urandom_range(0, 70)) send_user(USR_RIGHT);
          send_tick();
          repeat ($urandom_range(0, 70)) send_user(USR_LEFT);
          send_user(($urandom_range(0, 1) != 0) ? USR_CONTINUE : USR_RESTART);
        end
        3: begin
          repeat (4) begin
            op = 2'($urandom);
            if (op == ITEM_TICK) send_tick();
            else push_item(op, 5'($urandom), 8'($urandom), 3'($urandom));
          end
        end
        default: begin
          if (mdl_status == ST_PAUSE) send_user(USR_CONTINUE);
          repeat ($urandom_range(5, 30)) begin
            case ($urandom_range(0, 11))
              0: send_load(5'($urandom), rand_word());
              1: send_user(3'($urandom_range(0, 5)));
              default: send_tick();
            endcase
          end
        end
      endcase
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() != 0 || in_valid || expected_views.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_bad == 0 && expected_views.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_views.push_back(in_flight.res);
        n_taken <= n_taken + 1;
      end
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() == 0 ||
                   (pending_items[0].drain && n_taken + int'(in_valid) != n_seen)) begin
        in_valid <= 1'b0;
      end else begin
        in_flight = pending_items.pop_front();
        in_valid <= 1'b1;
        in_opcode <= in_flight.op;
        in_load_index <= in_flight.idx;
        in_recipe_word <= in_flight.word;
        in_user_action <= in_flight.act;
        send_gap <= in_flight.gap;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_views.size() == 0) begin
          if (n_bad < REPORT_MAX) $display("tb: result %0d arrived with no item pending", n_seen);
          n_bad++;
        end else begin
          want = expected_views.pop_front();
          if (out_pulse_width !== want.pulse || out_run_status !== want.status ||
              out_program_index !== want.index) begin
            if (n_bad < REPORT_MAX) begin
              $display("tb: mismatch at result %0d: expected pulse %0d status %0d index %0d",
                       n_seen, want.pulse, want.status, want.index);
              $display("tb:   got pulse %0d status %0d index %0d",
                       out_pulse_width, out_run_status, out_program_index);
            end
            n_bad++;
          end
        end
        n_seen <= n_seen + 1;
        rx_wait = draw_idle(n_seen + 20);
        if (!hold_done && n_seen == HOLD_AT) begin
          rx_wait = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
